// ===== hw/rtl/skt_pkg.sv =====
// Shared widths, codes and control types for the sorted key table.
package skt_pkg;

   localparam int CAPACITY_DEF = 128;

   localparam int KEY_W   = 31;
   localparam int PL_W    = 32;
   localparam int MODE_W  = 2;
   localparam int STAT_W  = 2;
   localparam int INDEX_W = 7;
   localparam int COUNT_W = 8;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic             cmp;     // capture compare flags
      logic             op_ins;  // request is an insert (selects head vs hit)
      logic             ins;     // apply insert this cycle
      logic             del;     // apply delete this cycle
      logic [KEY_W-1:0] key;
      logic [PL_W-1:0]  payload;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/skt_cell.sv =====
// One table slot: holds an entry, compares it with the broadcast key and shifts.
module skt_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  skt_pkg::cell_ctrl_type      ctrl,
   input  logic                        occ,
   input  logic                        prev_occ,
   input  logic                        prev_lt,
   input  logic [skt_pkg::KEY_W-1:0]   prev_key,
   input  logic [skt_pkg::PL_W-1:0]    prev_payload,
   input  logic [skt_pkg::KEY_W-1:0]   next_key,
   input  logic [skt_pkg::PL_W-1:0]    next_payload,
   output logic [skt_pkg::KEY_W-1:0]   key,
   output logic [skt_pkg::PL_W-1:0]    payload,
   output logic                        lt,
   output logic                        pick,
   output logic                        order_ok
);

   logic [skt_pkg::KEY_W-1:0] key_ff, key_in;
   logic [skt_pkg::PL_W-1:0]  pl_ff, pl_in;
   logic                      lt_ff, lt_in;
   logic                      eq_ff, eq_in;
   logic                      ord_ff, ord_in;
   logic                      head, hit;

   assign lt_in  = occ & (key_ff < ctrl.key);
   assign eq_in  = occ & (key_ff == ctrl.key);
   assign ord_in = ~(occ & prev_occ & (prev_key > key_ff));

   // keys stay sorted, so the lt flags form a run from cell 0
   assign head = prev_lt & ~lt_ff;
   assign hit  = prev_lt & eq_ff;

   always_comb begin
      key_in = key_ff;
      pl_in  = pl_ff;
      if (ctrl.ins) begin
         if (head) begin
            key_in = ctrl.key;
            pl_in  = ctrl.payload;
         end else if (prev_occ & ~prev_lt) begin
            key_in = prev_key;
            pl_in  = prev_payload;
         end
      end else if (ctrl.del & occ & ~lt_ff) begin
         key_in = next_key;
         pl_in  = next_payload;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pl_ff  <= pl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff  <= 1'b0;
         eq_ff  <= 1'b0;
         ord_ff <= 1'b1;
      end else if (ctrl.cmp) begin
         lt_ff  <= lt_in;
         eq_ff  <= eq_in;
         ord_ff <= ord_in;
      end
   end

   assign key      = key_ff;
   assign payload  = pl_ff;
   assign lt       = lt_ff;
   assign pick     = ctrl.op_ins ? head : hit;
   assign order_ok = ord_ff;

endmodule

// ===== hw/rtl/skt_collect.sv =====
// Gathers the one-hot cell picks into a position and payload, plus the order check.
module skt_collect #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
   input  logic [CAPACITY-1:0]                        pick,
   input  logic [CAPACITY-1:0]                        order_ok,
   input  logic [CAPACITY-1:0][skt_pkg::PL_W-1:0]     payload,
   output logic                                       any,
   output logic [$clog2(CAPACITY)-1:0]                position,
   output logic [skt_pkg::PL_W-1:0]                   pick_payload,
   output logic                                       all_ok
);

   localparam int IW = $clog2(CAPACITY);

   always_comb begin
      position     = '0;
      pick_payload = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         position     = position | ({IW{pick[j]}} & IW'(j));
         pick_payload = pick_payload | ({skt_pkg::PL_W{pick[j]}} & payload[j]);
      end
   end

   assign any    = |pick;
   assign all_ok = &order_ok;

endmodule

// ===== hw/rtl/sorted_key_table.sv =====
// Sorted key table top level: request sequencer, cell chain and result register.
// Each request passes a compare state, then an apply state: in compare every
// cell compares its key with the request key in parallel and registers the
// flags; in apply the cells shift up (insert) or down (delete) by one place
// from the flagged position and the result is loaded into the output register.
// The next request is taken in the apply state while the result side keeps up;
// a stalled result holds the table in apply. Reset clears the entry count and
// the cell flags, not the entries, which are read only below the count.
module sorted_key_table #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [skt_pkg::MODE_W-1:0]    req_mode,
   input  logic [skt_pkg::KEY_W-1:0]     req_key,
   input  logic [skt_pkg::PL_W-1:0]      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [skt_pkg::STAT_W-1:0]    rsp_status,
   output logic [skt_pkg::INDEX_W-1:0]   rsp_index,
   output logic [skt_pkg::PL_W-1:0]      rsp_found_payload,
   output logic [skt_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic                          rsp_in_order
);

   localparam int IW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CMP   = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;

   logic [skt_pkg::MODE_W-1:0] mode_ff;
   logic [skt_pkg::KEY_W-1:0]  key_ff;
   logic [skt_pkg::PL_W-1:0]   pl_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [skt_pkg::STAT_W-1:0]  status_ff, status_in;
   logic [skt_pkg::INDEX_W-1:0] index_ff, index_in;
   logic [skt_pkg::PL_W-1:0]    fpl_ff, fpl_in;
   logic [skt_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        order_ff, order_in;

   logic req_take, apply_go, full;
   skt_pkg::cell_ctrl_type ctrl;

   logic [CAPACITY-1:0]                       occ, lt, pick, order_ok;
   logic [CAPACITY-1:0][skt_pkg::KEY_W-1:0]   cell_key;
   logic [CAPACITY-1:0][skt_pkg::PL_W-1:0]    cell_pl;

   logic                        any;
   logic [IW-1:0]               position;
   logic [skt_pkg::PL_W-1:0]    pick_pl;
   logic                        all_ok;
   logic [IW+skt_pkg::INDEX_W:0]  pos_wide;
   logic [FW+skt_pkg::COUNT_W:0]  fill_wide;

   assign full     = (fill_ff == FW'(CAPACITY));
   assign apply_go = (state_ff == S_APPLY) & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = ~((state_ff == S_IDLE) | apply_go);
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_take) state_in = S_CMP;
         S_CMP:   state_in = S_APPLY;
         S_APPLY: begin
            if (apply_go) state_in = req_take ? S_CMP : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
         pl_ff   <= req_payload;
      end
   end

   always_comb begin
      ctrl.cmp     = (state_ff == S_CMP);
      ctrl.op_ins  = (mode_ff == skt_pkg::MODE_INSERT);
      ctrl.ins     = apply_go & (mode_ff == skt_pkg::MODE_INSERT) & ~full;
      ctrl.del     = apply_go & (mode_ff == skt_pkg::MODE_DELETE) & any;
      ctrl.key     = key_ff;
      ctrl.payload = pl_ff;
   end

   for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      logic                       p_occ, p_lt;
      logic [skt_pkg::KEY_W-1:0]  p_key, n_key;
      logic [skt_pkg::PL_W-1:0]   p_pl, n_pl;

      assign occ[j] = (FW'(j) < fill_ff);

      if (j == 0) begin : g_first
         assign p_occ = 1'b0;
         assign p_lt  = 1'b1;
         assign p_key = '0;
         assign p_pl  = '0;
      end else begin : g_mid
         assign p_occ = occ[j-1];
         assign p_lt  = lt[j-1];
         assign p_key = cell_key[j-1];
         assign p_pl  = cell_pl[j-1];
      end

      if (j == CAPACITY - 1) begin : g_last
         assign n_key = cell_key[j];
         assign n_pl  = cell_pl[j];
      end else begin : g_inner
         assign n_key = cell_key[j+1];
         assign n_pl  = cell_pl[j+1];
      end

      skt_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .occ          (occ[j]),
         .prev_occ     (p_occ),
         .prev_lt      (p_lt),
         .prev_key     (p_key),
         .prev_payload (p_pl),
         .next_key     (n_key),
         .next_payload (n_pl),
         .key          (cell_key[j]),
         .payload      (cell_pl[j]),
         .lt           (lt[j]),
         .pick         (pick[j]),
         .order_ok     (order_ok[j])
      );
   end

   skt_collect #(
      .CAPACITY (CAPACITY)
   ) u_collect (
      .pick         (pick),
      .order_ok     (order_ok),
      .payload      (cell_pl),
      .any          (any),
      .position     (position),
      .pick_payload (pick_pl),
      .all_ok       (all_ok)
   );

   always_comb begin
      fill_in   = fill_ff;
      status_in = skt_pkg::ST_OK;
      pos_wide  = '0;
      fpl_in    = '0;
      order_in  = 1'b0;
      case (mode_ff)
         skt_pkg::MODE_INSERT: begin
            if (full) begin
               status_in = skt_pkg::ST_FULL;
            end else begin
               pos_wide = (IW + skt_pkg::INDEX_W + 1)'(position);
               fill_in  = fill_ff + FW'(1);
            end
         end
         skt_pkg::MODE_SEARCH, skt_pkg::MODE_DELETE: begin
            if (!any) begin
               status_in = skt_pkg::ST_NOT_FOUND;
            end else begin
               pos_wide = (IW + skt_pkg::INDEX_W + 1)'(position);
               fpl_in   = pick_pl;
               if (mode_ff == skt_pkg::MODE_DELETE) fill_in = fill_ff - FW'(1);
            end
         end
         skt_pkg::MODE_CHECK: order_in = all_ok;
         default: order_in = 1'b0;
      endcase
      fill_wide = (FW + skt_pkg::COUNT_W + 1)'(fill_in);
      index_in  = pos_wide[skt_pkg::INDEX_W-1:0];
      count_in  = fill_wide[skt_pkg::COUNT_W-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (apply_go) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (apply_go) fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (apply_go) begin
         status_ff <= status_in;
         index_ff  <= index_in;
         fpl_ff    <= fpl_in;
         count_ff  <= count_in;
         order_ff  <= order_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_index         = index_ff;
   assign rsp_found_payload = fpl_ff;
   assign rsp_entry_count   = count_ff;
   assign rsp_in_order      = order_ff;

endmodule

// ===== tb/sorted_key_table_test.sv =====
// Self-checking testbench for the sorted key table: directed cases, fill to full, random mix.
`timescale 1ns / 1ps

module sorted_key_table_test;
   import skt_pkg::*;

   localparam int TABLE_DEPTH = CAPACITY_DEF;

   typedef struct {
      logic [STAT_W-1:0]  status;
      logic [INDEX_W-1:0] index;
      logic [PL_W-1:0]    found_payload;
      logic [COUNT_W-1:0] entry_count;
      logic               in_order;
   } table_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode = MODE_CHECK;
   logic [KEY_W-1:0]    req_key = '0;
   logic [PL_W-1:0]     req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [INDEX_W-1:0]  rsp_index;
   logic [PL_W-1:0]     rsp_found_payload;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic                rsp_in_order;

   // shadow copy of the table contents
   logic [KEY_W-1:0]    shadow_keys [TABLE_DEPTH];
   logic [PL_W-1:0]     shadow_payloads [TABLE_DEPTH];
   int                  shadow_fill = 0;

   table_reply_type     expected_replies [$];
   int                  mismatch_count = 0;
   int                  req_gap_max = 0;
   int                  rsp_stall_max = 0;

   sorted_key_table #(.CAPACITY(TABLE_DEPTH)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_index         (rsp_index),
      .rsp_found_payload (rsp_found_payload),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_in_order      (rsp_in_order)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one request to the shadow table and return the reply it should give.
   function automatic table_reply_type apply_request(input logic [MODE_W-1:0] mode,
                                                     input logic [KEY_W-1:0]  key,
                                                     input logic [PL_W-1:0]   payload);
      table_reply_type r;
      int pos;
      int j;
      r.status        = ST_OK;
      r.index         = '0;
      r.found_payload = '0;
      r.in_order      = 1'b0;
      pos = 0;
      case (mode)
         MODE_INSERT: begin
            if (shadow_fill >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // lands after all smaller keys, so ahead of any equal ones
               while (pos < shadow_fill && shadow_keys[pos] < key) pos++;
               for (j = shadow_fill; j > pos; j--) begin
                  shadow_keys[j]     = shadow_keys[j-1];
                  shadow_payloads[j] = shadow_payloads[j-1];
               end
               shadow_keys[pos]     = key;
               shadow_payloads[pos] = payload;
               shadow_fill++;
               r.index = INDEX_W'(pos);
            end
         end
         MODE_SEARCH, MODE_DELETE: begin
            while (pos < shadow_fill && shadow_keys[pos] != key) pos++;
            if (pos >= shadow_fill) begin
               r.status = ST_NOT_FOUND;
            end else begin
               r.index         = INDEX_W'(pos);
               r.found_payload = shadow_payloads[pos];
               if (mode == MODE_DELETE) begin
                  for (j = pos + 1; j < shadow_fill; j++) begin
                     shadow_keys[j-1]     = shadow_keys[j];
                     shadow_payloads[j-1] = shadow_payloads[j];
                  end
                  shadow_fill--;
               end
            end
         end
         MODE_CHECK: begin
            r.in_order = 1'b1;
            for (j = 1; j < shadow_fill; j++)
               if (shadow_keys[j-1] > shadow_keys[j]) r.in_order = 1'b0;
         end
         default: ;
      endcase
      r.entry_count = COUNT_W'(shadow_fill);
      return r;
   endfunction

   // A held key when asked for a hit and the table has one, else a fresh key.
   function automatic logic [KEY_W-1:0] pick_key(input bit hit);
      logic [KEY_W-1:0] k;
      if (hit && shadow_fill > 0) begin
         k = shadow_keys[$urandom_range(0, shadow_fill - 1)];
      end else begin
         case ($urandom_range(0, 3))
            0:       k = KEY_W'($urandom_range(0, 40));
            1:       k = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 3));
            default: k = KEY_W'($urandom);
         endcase
      end
      return k;
   endfunction

   // Leaves valid high after the transfer; the next call either drives the
   // next request in the same step or drops valid for its gap.
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [KEY_W-1:0]  key,
                               input logic [PL_W-1:0]   payload);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_key     <= key;
      req_payload <= payload;
      do @(posedge clock); while (req_stall);
      expected_replies.push_back(apply_request(mode, key, payload));
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : reply_checker
      table_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            $error("reply with none outstanding: status %0d index %0d count %0d",
                   rsp_status, rsp_index, rsp_entry_count);
            mismatch_count++;
         end else begin
            want = expected_replies.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("index", 32'(want.index), 32'(rsp_index));
            check_field("found_payload", want.found_payload, rsp_found_payload);
            check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
            check_field("in_order", 32'(want.in_order), 32'(rsp_in_order));
         end
      end
   end

   initial begin : rsp_backpressure
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = $urandom_range(0, rsp_stall_max);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic test_empty_table();
      req_gap_max   = 11;
      rsp_stall_max = 11;
      send_request(MODE_CHECK, KEY_W'($urandom), $urandom);
      send_request(MODE_SEARCH, 31'd5, 32'hFFFF_FFFF);
      send_request(MODE_DELETE, {KEY_W{1'b1}}, $urandom);
   endtask

   task automatic test_duplicate_keys();
      req_gap_max   = 0;
      rsp_stall_max = 11;
      send_request(MODE_INSERT, {KEY_W{1'b1}}, 32'hFFFF_FFFF);
      send_request(MODE_CHECK, '0, '0);                 // single entry
      send_request(MODE_INSERT, 31'd1, 32'h0000_0000);
      send_request(MODE_INSERT, 31'd0, 32'hA5A5_A5A5);  // key zero
      send_request(MODE_INSERT, 31'd1, 32'h5A5A_5A5A);  // goes ahead of the older 1
      send_request(MODE_SEARCH, 31'd1, $urandom);
      send_request(MODE_SEARCH, {KEY_W{1'b1}}, $urandom);
      send_request(MODE_CHECK, KEY_W'($urandom), $urandom);
      send_request(MODE_DELETE, 31'd1, $urandom);
      send_request(MODE_SEARCH, 31'd1, $urandom);
      send_request(MODE_DELETE, 31'd0, $urandom);
      send_request(MODE_DELETE, {KEY_W{1'b1}}, $urandom);
      send_request(MODE_DELETE, 31'd1, $urandom);
      send_request(MODE_DELETE, 31'd1, $urandom);       // now missing
      send_request(MODE_SEARCH, 31'h2AAA_AAAA, 32'hFFFF_FFFF);
      send_request(MODE_CHECK, {KEY_W{1'b1}}, 32'hFFFF_FFFF);
   endtask

   task automatic test_fill_to_full();
      req_gap_max   = 0;
      rsp_stall_max = 3;
      while (shadow_fill < TABLE_DEPTH)
         send_request(MODE_INSERT, pick_key(1'b0), $urandom);
      repeat (3) send_request(MODE_INSERT, pick_key($urandom_range(0, 1)), $urandom);
      send_request(MODE_SEARCH, pick_key(1'b1), $urandom);
      send_request(MODE_SEARCH, pick_key(1'b0), $urandom);
      send_request(MODE_DELETE, pick_key(1'b0), $urandom);
      send_request(MODE_CHECK, pick_key(1'b0), $urandom);
      send_request(MODE_DELETE, pick_key(1'b1), $urandom);
      send_request(MODE_INSERT, pick_key(1'b0), $urandom);
      send_request(MODE_INSERT, pick_key(1'b0), $urandom);
      // drain with deletes of held keys, checking order now and then
      req_gap_max   = 11;
      rsp_stall_max = 0;
      while (shadow_fill > 0) begin
         send_request(MODE_DELETE, pick_key(1'b1), $urandom);
         if ($urandom_range(0, 15) == 0) send_request(MODE_CHECK, pick_key(1'b0), $urandom);
      end
      send_request(MODE_CHECK, pick_key(1'b0), $urandom);
   endtask

   task automatic test_random_mix();
      int roll;
      for (int burst = 0; burst < 6; burst++) begin
         req_gap_max   = (burst % 2 == 1) ? 11 : 0;
         rsp_stall_max = (burst % 4 >= 2) ? 11 : 0;
         repeat (110) begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
               send_request(MODE_INSERT, pick_key($urandom_range(0, 3) == 0), $urandom);
            else if (roll < 55)
               send_request(MODE_SEARCH, pick_key(1'b1), $urandom);
            else if (roll < 75)
               send_request(MODE_DELETE, pick_key(1'b1), $urandom);
            else if (roll < 88)
               send_request(roll[0] ? MODE_SEARCH : MODE_DELETE, pick_key(1'b0), $urandom);
            else
               send_request(MODE_CHECK, pick_key(1'b0), $urandom);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_duplicate_keys();
      test_fill_to_full();
      test_random_mix();
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("** sorted_key_table: PASSED **");
      else
         $display("** sorted_key_table: FAILED **");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("** sorted_key_table: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/skt_pkg.sv
hw/rtl/skt_cell.sv
hw/rtl/skt_collect.sv
hw/rtl/sorted_key_table.sv
tb/sorted_key_table_test.sv
